FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  parameter int COLUMNS_DEF = 80;
  parameter int ROWS_DEF    = 25;

  parameter int CELL_W      = 16;
  parameter int CODE_W      = 8;
  parameter int COLOUR_W    = 4;
  parameter int ROW_FIELD_W = 5;
  parameter int COL_FIELD_W = 7;
  parameter int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEF_BG,
    CFG_DEF_FG
  } cfg_idx_t;

  parameter logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
  parameter logic [CODE_W-1:0] CODE_TAB       = 8'd9;
  parameter logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
  parameter logic [CODE_W-1:0] CODE_RETURN    = 8'd13;
  parameter logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

  parameter logic [CELL_W-1:0]   BLANK_AT_RESET = 16'h0720;
  parameter logic [COLOUR_W-1:0] DEF_BG_RESET   = 4'd0;
  parameter logic [COLOUR_W-1:0] DEF_FG_RESET   = 4'd7;

endpackage

FILE: rtl/text_console_writer_core.sv
// text console writer: one item at a time, ready only when idle
// write or read: S_ADDR, S_MEM, S_DONE; result registered once the output is free
// newline or wrap on the bottom row: rows are a ring, so a scroll only refills
// one row, in S_FBASE and S_FILL through the single screen memory write port
// reset (synchronous, active low) clears cursor, sets colours to reset values,
// then sweeps the screen memory to blanks in S_CLEAR with no input taken
module text_console_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [tcw_pkg::CODE_W-1:0]        in_char_code,
  input  logic [tcw_pkg::COLOUR_W-1:0]      in_background,
  input  logic [tcw_pkg::COLOUR_W-1:0]      in_foreground,
  input  logic [tcw_pkg::ROW_FIELD_W-1:0]   in_read_row,
  input  logic [tcw_pkg::COL_FIELD_W-1:0]   in_read_column,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcw_pkg::ROW_FIELD_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::COL_FIELD_W-1:0]   out_cursor_column,
  output logic [tcw_pkg::CELL_W-1:0]        out_cell_data,

  input  logic                              cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcw_pkg::COLOUR_W-1:0]      cfg_wdata
);

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RF_W   = tcw_pkg::ROW_FIELD_W;
  localparam int CF_W   = tcw_pkg::COL_FIELD_W;
  localparam int CELL_W = tcw_pkg::CELL_W;

  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ROW_W:0]    ROWS_EXT  = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W-1:0] COLS_MUL  = ADDR_W'(COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_MEM,
    S_FBASE,
    S_FILL,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [ROW_W-1:0]              row_r, row_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [ROW_W-1:0]              top_r, top_nxt;
  logic [ADDR_W-1:0]             addr_r, addr_nxt;
  logic [COL_W-1:0]              fcnt_r, fcnt_nxt;
  logic [tcw_pkg::COLOUR_W-1:0]  def_bg_r, def_bg_nxt;
  logic [tcw_pkg::COLOUR_W-1:0]  def_fg_r, def_fg_nxt;

  logic                          act_r;
  logic [tcw_pkg::CODE_W-1:0]    code_r;
  logic [tcw_pkg::COLOUR_W-1:0]  bg_r;
  logic [tcw_pkg::COLOUR_W-1:0]  fg_r;
  logic [RF_W-1:0]               rd_row_r;
  logic [CF_W-1:0]               rd_col_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]              out_row_r, out_row_nxt;
  logic [COL_W-1:0]              out_col_r, out_col_nxt;
  logic [CELL_W-1:0]             out_data_r, out_data_nxt;

  logic                          in_xfer;
  logic                          out_free;
  logic                          rd_in_range;

  // shared address unit: logical row and column to memory address
  logic [ROW_W-1:0]              lrow_sel;
  logic [COL_W-1:0]              col_sel;
  logic [ROW_W:0]                row_sum;
  logic [ROW_W-1:0]              prow;
  logic [ADDR_W-1:0]             addr_calc;

  logic                          ram_we;
  logic [CELL_W-1:0]             ram_wdata;
  logic [CELL_W-1:0]             ram_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign rd_in_range = (32'(rd_row_r) < 32'(ROWS)) && (32'(rd_col_r) < 32'(COLUMNS));

  always_comb begin
    if (state_r == S_FBASE) begin
      lrow_sel = LAST_ROW;
      col_sel  = '0;
    end else if (act_r) begin
      lrow_sel = ROW_W'(rd_row_r);
      col_sel  = COL_W'(rd_col_r);
    end else begin
      lrow_sel = row_r;
      col_sel  = col_r;
    end
    row_sum   = {1'b0, lrow_sel} + {1'b0, top_r};
    prow      = (row_sum >= ROWS_EXT) ? ROW_W'(row_sum - ROWS_EXT) : ROW_W'(row_sum);
    addr_calc = ADDR_W'(prow) * COLS_MUL + ADDR_W'(col_sel);
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    top_nxt       = top_r;
    addr_nxt      = addr_r;
    fcnt_nxt      = fcnt_r;
    def_bg_nxt    = def_bg_r;
    def_fg_nxt    = def_fg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_wdata     = {bg_r, fg_r, code_r};

    if (cfg_we) begin
      if (cfg_index == tcw_pkg::CFG_DEF_BG) begin
        def_bg_nxt = cfg_wdata;
      end else if (cfg_index == tcw_pkg::CFG_DEF_FG) begin
        def_fg_nxt = cfg_wdata;
      end
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::BLANK_AT_RESET;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        addr_nxt  = addr_calc;
        state_nxt = S_MEM;
      end
      S_MEM: begin
        state_nxt = S_DONE;
        if (!act_r) begin
          if (code_r == tcw_pkg::CODE_RETURN) begin
            col_nxt = '0;
          end else if (code_r != tcw_pkg::CODE_BACKSPACE &&
                       code_r != tcw_pkg::CODE_TAB) begin
            if (code_r != tcw_pkg::CODE_NEWLINE) begin
              ram_we = 1'b1;
            end
            if (code_r == tcw_pkg::CODE_NEWLINE || col_r == LAST_COL) begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                // scroll: old top row becomes the new bottom row
                top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
                state_nxt = S_FBASE;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
      end
      S_FBASE: begin
        addr_nxt  = addr_calc;
        fcnt_nxt  = '0;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {def_bg_r, def_fg_r, tcw_pkg::CODE_SPACE};
        addr_nxt  = addr_r + 1'b1;
        fcnt_nxt  = fcnt_r + 1'b1;
        if (fcnt_r == LAST_COL) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          out_data_nxt  = (act_r && rd_in_range) ? ram_rdata : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      top_r       <= '0;
      addr_r      <= '0;
      fcnt_r      <= '0;
      def_bg_r    <= tcw_pkg::DEF_BG_RESET;
      def_fg_r    <= tcw_pkg::DEF_FG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      top_r       <= top_nxt;
      addr_r      <= addr_nxt;
      fcnt_r      <= fcnt_nxt;
      def_bg_r    <= def_bg_nxt;
      def_fg_r    <= def_fg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      act_r    <= in_action;
      code_r   <= in_char_code;
      bg_r     <= in_background;
      fg_r     <= in_foreground;
      rd_row_r <= in_read_row;
      rd_col_r <= in_read_column;
    end
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_row    = RF_W'(out_row_r);
  assign out_cursor_column = CF_W'(out_col_r);
  assign out_cell_data     = out_data_r;

`ifndef SYNTHESIS
  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= LAST_ROW) else $error("cursor row beyond last row");

  a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= LAST_COL) else $error("cursor column beyond last column");

  a_top_row: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LAST_ROW) else $error("ring top row out of range");

  a_fill_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL || state_r == S_CLEAR) |-> addr_r <= LAST_ADDR)
    else $error("blank fill address outside screen");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM && act_r) |=> (state_r == S_DONE && !$past(ram_we)))
    else $error("read item wrote the screen or skipped completion");
`endif

endmodule

FILE: rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
